// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: capacity, entry
// layout, command group for the cell chain and the request/response beats.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  age;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_cmd_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  prio;
    logic [7:0]  age;
    logic [15:0] record_tag;
  } spq_req_t;

  typedef struct packed {
    logic        head_valid;
    logic [7:0]  head_prio;
    logic [7:0]  head_age;
    logic [15:0] head_tag;
    logic [4:0]  occupancy;
    logic        dropped;
    logic        empty_remove;
  } spq_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. On insert it keeps its entry, takes the new
// entry or takes its left neighbor's; on remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_cmd_t cmd,
  input  wire logic      occupied,
  input  wire logic      left_le,
  input  wire entry_t    left_slot,
  input  wire entry_t    right_slot,
  output logic           le,
  output entry_t         slot,
  output entry_t         slot_next
);

  assign le = occupied && (slot.prio <= cmd.item.prio);

  always_comb begin
    slot_next = slot;
    if (cmd.ins) begin
      if (!le) begin
        slot_next = left_le ? cmd.item : left_slot;
      end
    end else if (cmd.rem) begin
      slot_next = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

`default_nettype wire

// ----- rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted shift-register priority queue built from a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req beats carry an insert (prio, age, record_tag) or a remove of the head.
//   Every req beat yields exactly one rsp beat with the head entry after the
//   operation, the occupancy and the dropped / empty_remove flags.
//   Lower prio sits nearer the head; equal prio keeps arrival order.
//   Latency: the rsp beat is valid the cycle after the req beat is taken.
//   Throughput: one req beat per cycle; every cell compares its slot against
//   the new priority in parallel and shifts in the same cycle.
//   The rsp register frees in the cycle it is taken, so req_ready stays high
//   while rsp_ready is high. When the receiver stalls, req_ready drops
//   until the pending rsp beat is taken.
//   Reset: the queue empties and no rsp beat is pending; slot contents are
//   not cleared, only fill_count.
//   Insert into a full queue is dropped; remove from an empty queue is a no-op.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire spq_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output spq_rsp_t      rsp
);

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             accept;
  logic             full;
  logic             empty;
  cell_cmd_t        cmd;
  logic             le_vec [CAPACITY];
  entry_t           slots [CAPACITY];
  entry_t           slots_next [CAPACITY];
  spq_rsp_t         rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (fill_count == CNT_W'(CAPACITY));
  assign empty     = (fill_count == '0);

  assign cmd.ins       = accept && (req.op == OP_INSERT) && !full;
  assign cmd.rem       = accept && (req.op == OP_REMOVE) && !empty;
  assign cmd.item.prio = req.prio;
  assign cmd.item.age  = req.age;
  assign cmd.item.tag  = req.record_tag;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   l_le;
    entry_t l_slot;
    entry_t r_slot;

    assign occ = (CNT_W'(i) < fill_count);

    if (i == 0) begin : g_first
      assign l_le   = 1'b1;
      assign l_slot = cmd.item;
    end else begin : g_mid
      assign l_le   = le_vec[i-1];
      assign l_slot = slots[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_slot = slots[i];
    end else begin : g_inner
      assign r_slot = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ),
      .left_le    (l_le),
      .left_slot  (l_slot),
      .right_slot (r_slot),
      .le         (le_vec[i]),
      .slot       (slots[i]),
      .slot_next  (slots_next[i])
    );
  end

  always_comb begin
    fill_count_next = fill_count;
    if (cmd.ins) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (cmd.rem) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_next              = '0;
    rsp_next.head_valid   = (fill_count_next != '0);
    if (fill_count_next != '0) begin
      rsp_next.head_prio  = slots_next[0].prio;
      rsp_next.head_age   = slots_next[0].age;
      rsp_next.head_tag   = slots_next[0].tag;
    end
    rsp_next.occupancy    = 5'(fill_count_next);
    rsp_next.dropped      = (req.op == OP_INSERT) && full;
    rsp_next.empty_remove = (req.op == OP_REMOVE) && empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill_count above capacity");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.dropped && rsp.empty_remove))
    else $error("both flags set");

  a_head_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.head_valid == (rsp.occupancy != '0)))
    else $error("head_valid disagrees with occupancy");

  a_occ_track: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp.occupancy == 5'(fill_count)))
    else $error("occupancy differs from fill_count");

  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("rsp beat pending after reset");

endmodule

`default_nettype wire

// ----- test/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the stable priority queue. It keeps its own sorted
// entry list, works out the head report for each accepted request beat, and
// compares each accepted response beat field by field with the oldest one.
// ----------------------------------------------------------------------------

module spq_checker
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  spq_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  spq_rsp_t rsp,
  output int       fail_count,
  output int       pending
);

  entry_t   sorted_entries[$];
  spq_rsp_t expected_heads[$];

  initial begin
    fail_count = 0;
    pending <= 0;
  end

  // apply one request to the entry list and return the head report
  function automatic spq_rsp_t advance_queue(spq_req_t r);
    spq_rsp_t o;
    entry_t   e;
    int       pos;
    o = '0;
    if (r.op == OP_INSERT) begin
      if (sorted_entries.size() >= CAPACITY) begin
        o.dropped = 1'b1;
      end else begin
        pos = 0;
        // equal priority goes behind older entries
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= r.prio)
          pos++;
        e.prio = r.prio;
        e.age  = r.age;
        e.tag  = r.record_tag;
        sorted_entries.insert(pos, e);
      end
    end else if (sorted_entries.size() == 0) begin
      o.empty_remove = 1'b1;
    end else begin
      void'(sorted_entries.pop_front());
    end
    if (sorted_entries.size() > 0) begin
      o.head_valid = 1'b1;
      o.head_prio  = sorted_entries[0].prio;
      o.head_age   = sorted_entries[0].age;
      o.head_tag   = sorted_entries[0].tag;
    end
    o.occupancy = 5'(sorted_entries.size());
    return o;
  endfunction

  function automatic int field_bad(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    spq_rsp_t want;
    int       bad;
    if (rst) begin
      sorted_entries.delete();
      expected_heads.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_heads.size() == 0) begin
          $display("%0t: unexpected response beat, expected none, actual %h", $time, rsp);
          fail_count++;
        end else begin
          want = expected_heads.pop_front();
          bad = field_bad("head_valid", want.head_valid, rsp.head_valid)
              + field_bad("head_prio", want.head_prio, rsp.head_prio)
              + field_bad("head_age", want.head_age, rsp.head_age)
              + field_bad("head_tag", want.head_tag, rsp.head_tag)
              + field_bad("occupancy", want.occupancy, rsp.occupancy)
              + field_bad("dropped", want.dropped, rsp.dropped)
              + field_bad("empty_remove", want.empty_remove, rsp.empty_remove);
          if (bad != 0) fail_count++;
        end
      end
      if (req_valid && req_ready) expected_heads.push_back(advance_queue(req));
    end
    pending <= expected_heads.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and remove beats into the stable priority queue: a directed
// pass over empty, full, tie and extreme-value cases, then random traffic
// that swings between filling and draining, with random idling on both
// sides and one long response stall. The checker judges every response.
// ----------------------------------------------------------------------------

module tb_top;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int QUIET_ITEMS  = 150;

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  spq_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  spq_rsp_t rsp;
  int       fail_count;
  int       pending;

  int       sent_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       cycles = 0;

  always #5 clk = ~clk;

  stable_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  spq_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic spq_req_t mk_req(op_e op, int prio, int age, int tag);
    spq_req_t r;
    r.op         = op;
    r.prio       = 8'(prio);
    r.age        = 8'(age);
    r.record_tag = 16'(tag);
    return r;
  endfunction

  function automatic spq_req_t random_req(int insert_pct);
    spq_req_t r;
    r.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    case ($urandom_range(0, 3))
      0: r.prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
      1: r.prio = 8'($urandom_range(0, 3));
      2: r.prio = 8'($urandom_range(250, 255));
      default: r.prio = 8'($urandom_range(0, 255));
    endcase
    r.age        = ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom_range(0, 255));
    r.record_tag = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(spq_req_t r);
    int gap;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 10);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // response side: random stall bursts plus one long hold
  initial begin : receiver
    int  gap;
    bit  held;
    held = 1'b0;
    rsp_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!held && sent_count >= 300) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (60) @(negedge clk);
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        gap = $urandom_range(1, 10);
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    int left;
    int insert_pct;
    int seg;
    int i;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty remove, extremes, ties, fill up, full insert, removes
    send_beat(mk_req(OP_REMOVE, 8'hff, 8'hff, 16'hffff));
    send_beat(mk_req(OP_INSERT, 8'hff, 8'h00, 16'h0000));
    send_beat(mk_req(OP_INSERT, 8'h00, 8'hff, 16'hffff));
    send_beat(mk_req(OP_INSERT, 8'h05, 8'h01, 16'h0001));
    send_beat(mk_req(OP_INSERT, 8'h05, 8'h02, 16'h0002));
    send_beat(mk_req(OP_INSERT, 8'h05, 8'h03, 16'h0003));
    send_beat(mk_req(OP_INSERT, 8'h00, 8'h04, 16'h0004));
    send_beat(mk_req(OP_INSERT, 8'hff, 8'h05, 16'h0005));
    for (i = 0; i < 9; i++)
      send_beat(mk_req(OP_INSERT, (i * 37) % 256, 8'h10 + i, 16'ha5a0 + i));
    send_beat(mk_req(OP_INSERT, 8'h00, 8'haa, 16'h5555));
    send_beat(mk_req(OP_REMOVE, 8'h00, 8'h00, 16'h0000));
    send_beat(mk_req(OP_REMOVE, 8'h00, 8'h00, 16'h0000));
    send_beat(mk_req(OP_REMOVE, 8'h00, 8'h00, 16'h0000));

    left = RANDOM_ITEMS;
    while (left > 0) begin
      seg = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 15;
        default: recv_idle_pct = 40;
      endcase
      while (seg > 0 && left > 0) begin
        if (left <= QUIET_ITEMS) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_beat(random_req(insert_pct));
        seg--;
        left--;
      end
    end

    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
test/spq_checker.sv
test/tb_top.sv
